// ===== rtl/core/conv3_pkg.sv =====
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared types and constants of the 3x3 replicate-border convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package conv3_pkg;

  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HEIGHT      = 4096;
  localparam int DEF_COEFF_FRAC_BITS = 12;

  localparam int COEFF_W = 16;
  localparam int PROD_W  = 25;
  localparam int ROW_W   = 27;
  localparam int SUM_W   = 29;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1024;
  localparam logic [47:0] COEFF_TOP_RST    = 48'h0000_0000_0000;
  localparam logic [47:0] COEFF_MID_RST    = 48'h0000_1000_0000;
  localparam logic [47:0] COEFF_BOT_RST    = 48'h0000_0000_0000;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEFF_TOP    = 3'd2,
    REG_COEFF_MID    = 3'd3,
    REG_COEFF_BOT    = 3'd4
  } cfg_reg_t;

  typedef logic [7:0] pix_t;

  // one window column, rows above, current and below
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    col_t left;
    col_t mid;
    col_t right;
  } win_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [11:0] row;
    logic        eof;
    logic        last;
  } meta_t;

  typedef struct packed {
    win_t  win;
    meta_t meta;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/conv3_line_store.sv =====
// ----------------------------------------------------------------------------
// conv3_line_store
// One line of pixels, three read copies, with bypass of the latest write.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_line_store #(
  parameter int DEPTH = conv3_pkg::DEF_MAX_WIDTH,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr [3],
  output logic [7:0]    rd_data [3],
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);
  import conv3_pkg::*;

  logic          byp_vld_r;
  logic [AW-1:0] byp_addr_r;
  pix_t          byp_data_r;

  // a read issued at the edge of a write sees the old word, so keep the last write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else if (wr_en) begin
      byp_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr_r <= wr_addr;
      byp_data_r <= wr_data;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_copy
    pix_t          mem [DEPTH];
    pix_t          q_r;
    logic [AW-1:0] addr_r;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        q_r    <= mem[rd_addr[g]];
        addr_r <= rd_addr[g];
      end
    end

    assign rd_data[g] = (byp_vld_r && addr_r == byp_addr_r) ? byp_data_r : q_r;
  end

endmodule

`default_nettype wire

// ===== rtl/core/conv3_win_cell.sv =====
// ----------------------------------------------------------------------------
// conv3_win_cell
// One column of the 3x3 window; takes its neighbor's column on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_win_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  conv3_pkg::col_t   d,
  output conv3_pkg::col_t   q
);
  import conv3_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= d;
    end
  end

  assign q = col_r;

endmodule

`default_nettype wire

// ===== rtl/core/conv3_mac.sv =====
// ----------------------------------------------------------------------------
// conv3_mac
// Weighted sum of a 3x3 window, magnitude, shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_mac #(
  parameter int COEFF_FRAC_BITS = conv3_pkg::DEF_COEFF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [47:0]       coeff_top,
  input  logic [47:0]       coeff_mid,
  input  logic [47:0]       coeff_bot,
  input  logic              job_vld,
  input  conv3_pkg::job_t   job,
  output logic              job_rdy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel,
  output logic [9:0]        out_col,
  output logic [11:0]       out_row,
  output logic              out_end_of_frame,
  output logic              out_last_of_run
);
  import conv3_pkg::*;

  logic a_vld_r, b_vld_r, c_vld_r, out_valid_r;
  logic a_adv, b_adv, c_adv, d_adv;

  job_t                      a_job_r;
  meta_t                     b_meta_r, c_meta_r;
  logic signed [PROD_W-1:0]  b_prod_r [9];
  logic signed [PROD_W-1:0]  prod_nxt [9];
  logic signed [ROW_W-1:0]   c_row_r [3];
  logic signed [ROW_W-1:0]   row_nxt [3];
  logic [47:0]               kreg [3];
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]          mag;
  logic [SUM_W-1:0]          shifted;
  logic [7:0]                pix_nxt;
  logic [7:0]                out_pixel_r;
  meta_t                     out_meta_r;

  function automatic pix_t pick(input col_t c, input int k);
    pix_t p;
    case (k)
      0:       p = c.top;
      1:       p = c.mid;
      default: p = c.bot;
    endcase
    return p;
  endfunction

  assign kreg[0] = coeff_top;
  assign kreg[1] = coeff_mid;
  assign kreg[2] = coeff_bot;

  assign d_adv   = !out_valid_r || out_ready;
  assign c_adv   = !c_vld_r || d_adv;
  assign b_adv   = !b_vld_r || c_adv;
  assign a_adv   = !a_vld_r || b_adv;
  assign job_rdy = a_adv;

  always_comb begin
    col_t                     cols [3];
    logic signed [COEFF_W-1:0] cf;
    logic signed [8:0]         px;
    logic signed [PROD_W-1:0]  pf;
    cols[0] = a_job_r.win.left;
    cols[1] = a_job_r.win.mid;
    cols[2] = a_job_r.win.right;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        cf = kreg[k][COEFF_W*j +: COEFF_W];
        px = {1'b0, pick(cols[j], k)};
        pf = cf * px;
        prod_nxt[k*3+j] = pf;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_nxt[k] = ROW_W'(b_prod_r[k*3]) + ROW_W'(b_prod_r[k*3+1]) +
                   ROW_W'(b_prod_r[k*3+2]);
    end
  end

  always_comb begin
    sum     = SUM_W'(c_row_r[0]) + SUM_W'(c_row_r[1]) + SUM_W'(c_row_r[2]);
    mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    shifted = mag >> COEFF_FRAC_BITS;
    pix_nxt = (shifted > SUM_W'(255)) ? 8'hFF : shifted[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_adv) a_vld_r <= job_vld;
      if (b_adv) b_vld_r <= a_vld_r;
      if (c_adv) c_vld_r <= b_vld_r;
      if (d_adv) out_valid_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && job_vld) a_job_r <= job;
    if (b_adv && a_vld_r) begin
      b_prod_r <= prod_nxt;
      b_meta_r <= a_job_r.meta;
    end
    if (c_adv && b_vld_r) begin
      c_row_r  <= row_nxt;
      c_meta_r <= b_meta_r;
    end
    if (d_adv && c_vld_r) begin
      out_pixel_r <= pix_nxt;
      out_meta_r  <= c_meta_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pixel_r;
  assign out_col          = out_meta_r.col;
  assign out_row          = out_meta_r.row;
  assign out_end_of_frame = out_meta_r.eof;
  assign out_last_of_run  = out_meta_r.last;

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && b_vld_r && c_vld_r && out_valid_r && !out_ready) |-> !job_rdy)
    else $error("mac takes a job while every stage is stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/conv3x3_replicate_border.sv =====
// Path: an input transfer is registered in stage 1, then in mac stages a, b, c and the output.
// Throughput: one item per cycle while out_ready holds; an item with two results holds the input
//   until its second job is taken, since the result port carries one transfer per cycle.
// Reset: synchronous, clears counters, window, pipeline valids and registers to
//   their defaults; the line stores are not cleared.
// ----------------------------------------------------------------------------
// conv3x3_replicate_border
// Streaming 3x3 convolution of a grey frame with replicated borders.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_replicate_border #(
  parameter int MAX_WIDTH       = conv3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = conv3_pkg::DEF_MAX_HEIGHT,
  parameter int COEFF_FRAC_BITS = conv3_pkg::DEF_COEFF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel,
  output logic [9:0]  out_col,
  output logic [11:0] out_row,
  output logic        out_end_of_frame,
  output logic        out_last_of_run
);
  import conv3_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [10:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [47:0] coeff_top_r, coeff_mid_r, coeff_bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      coeff_top_r    <= COEFF_TOP_RST;
      coeff_mid_r    <= COEFF_MID_RST;
      coeff_bot_r    <= COEFF_BOT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[12:0];
        REG_COEFF_TOP:    coeff_top_r    <= cfg_wdata;
        REG_COEFF_MID:    coeff_mid_r    <= cfg_wdata;
        REG_COEFF_BOT:    coeff_bot_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective frame size, last column and last row
  logic [11:0]   w_clip;
  logic [13:0]   h_clip;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  always_comb begin
    w_clip = {1'b0, frame_width_r};
    if (w_clip == 12'd0) w_clip = 12'd1;
    if (32'(w_clip) > MAX_WIDTH) w_clip = 12'(MAX_WIDTH);
    h_clip = {1'b0, frame_height_r};
    if (h_clip == 14'd0) h_clip = 14'd1;
    if (32'(h_clip) > MAX_HEIGHT) h_clip = 14'(MAX_HEIGHT);
    wm1 = CW'(w_clip - 12'd1);
    hm1 = RW'(h_clip - 14'd1);
  end

  // position state
  logic [CW-1:0] col_count_r;
  logic [RW-1:0] row_count_r;
  logic          drain_pend_r;
  logic [CW-1:0] drain_col_r;

  logic in_xfer, s1_load, s1_adv;
  logic row_end, frame_end, drain_last;
  logic j1, j2, j3;
  logic [CW:0]   kp1;
  logic [CW-1:0] rd_addr [3];

  assign in_xfer = in_valid && in_ready;
  assign s1_load = in_xfer && (!in_req_type || drain_pend_r);

  always_comb begin
    row_end    = col_count_r >= wm1;
    frame_end  = row_end && row_count_r >= hm1;
    drain_last = drain_col_r >= wm1;
    j1 = col_count_r == '0 && 32'(row_count_r) >= 32'd2;
    j2 = col_count_r != '0 && row_count_r != '0;
    j3 = frame_end && row_count_r != '0;
    kp1 = {1'b0, drain_col_r} + (CW+1)'(1);
    if (in_req_type) begin
      rd_addr[0] = (drain_col_r != '0) ? drain_col_r - CW'(1) : drain_col_r;
      if (rd_addr[0] > wm1) rd_addr[0] = wm1;
      rd_addr[1] = (drain_col_r > wm1) ? wm1 : drain_col_r;
      rd_addr[2] = (kp1 > {1'b0, wm1}) ? wm1 : kp1[CW-1:0];
    end else begin
      rd_addr[0] = col_count_r;
      rd_addr[1] = col_count_r;
      rd_addr[2] = col_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r  <= '0;
      row_count_r  <= '0;
      drain_pend_r <= 1'b0;
      drain_col_r  <= '0;
    end else if (in_xfer) begin
      if (in_req_type) begin
        if (drain_pend_r) begin
          if (drain_last) drain_pend_r <= 1'b0;
          else drain_col_r <= drain_col_r + CW'(1);
        end
      end else begin
        drain_pend_r <= frame_end;
        if (frame_end) begin
          col_count_r  <= '0;
          row_count_r  <= '0;
          drain_col_r  <= '0;
        end else if (row_end) begin
          col_count_r <= '0;
          row_count_r <= row_count_r + RW'(1);
        end else begin
          col_count_r <= col_count_r + CW'(1);
        end
      end
    end
  end

  // stage 1: line store data arrives, window shifts, jobs go out
  logic          s1_vld_r, s1_first_done_r;
  logic          s1_is_drain_r, s1_j1_r, s1_j2_r, s1_j3_r;
  logic          s1_top1_r, s1_top23_r, s1_wge2_r, s1_cis1_r, s1_dlast_r;
  pix_t          s1_pix_r;
  logic [CW-1:0] s1_waddr_r;
  logic [11:0]   s1_row1_r, s1_row23_r;
  logic [9:0]    s1_col2_r, s1_colw_r;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_is_drain_r <= in_req_type;
      s1_j1_r       <= j1;
      s1_j2_r       <= j2;
      s1_j3_r       <= j3;
      s1_wge2_r     <= wm1 != '0;
      s1_cis1_r     <= col_count_r == CW'(1);
      s1_pix_r      <= in_pixel;
      s1_waddr_r    <= col_count_r;
      s1_colw_r     <= 10'(wm1);
      s1_dlast_r    <= drain_last;
      s1_top1_r     <= 32'(row_count_r) == 32'd2;
      s1_row1_r     <= 12'(row_count_r - RW'(2));
      if (in_req_type) begin
        s1_col2_r  <= 10'(drain_col_r);
        s1_row23_r <= 12'(hm1);
        s1_top23_r <= hm1 == '0;
      end else begin
        s1_col2_r  <= 10'(col_count_r - CW'(1));
        s1_row23_r <= 12'(row_count_r - RW'(1));
        s1_top23_r <= 32'(row_count_r) == 32'd1;
      end
    end
  end

  pix_t up_rd [3];
  pix_t lo_rd [3];
  logic st_wr;

  assign st_wr = s1_adv && !s1_is_drain_r;

  conv3_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_load),
    .rd_addr (rd_addr),
    .rd_data (up_rd),
    .wr_en   (st_wr),
    .wr_addr (s1_waddr_r),
    .wr_data (lo_rd[1])
  );

  conv3_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lower (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_load),
    .rd_addr (rd_addr),
    .rd_data (lo_rd),
    .wr_en   (st_wr),
    .wr_addr (s1_waddr_r),
    .wr_data (s1_pix_r)
  );

  // window: cell 2 newest, cell 0 oldest
  col_t newcol, p0, p1, p2;

  assign newcol = '{top: up_rd[1], mid: lo_rd[1], bot: s1_pix_r};

  conv3_win_cell u_cell2 (.clk(clk), .rst_n(rst_n), .shift(st_wr), .d(newcol), .q(p2));
  conv3_win_cell u_cell1 (.clk(clk), .rst_n(rst_n), .shift(st_wr), .d(p2), .q(p1));
  conv3_win_cell u_cell0 (.clk(clk), .rst_n(rst_n), .shift(st_wr), .d(p1), .q(p0));

  function automatic win_t fix_top(input win_t w, input logic top_edge);
    win_t o;
    o = w;
    if (top_edge) begin
      o.left.top  = w.left.mid;
      o.mid.top   = w.mid.mid;
      o.right.top = w.right.mid;
    end
    return o;
  endfunction

  logic two, has_job, job_vld, job_rdy, job_last;
  job_t job;
  win_t win_r1, win_r2, win_r3, win_dr;

  always_comb begin
    two      = s1_j3_r && (s1_j1_r || s1_j2_r);
    has_job  = s1_is_drain_r || s1_j1_r || s1_j2_r || s1_j3_r;
    job_vld  = s1_vld_r && has_job;
    job_last = s1_is_drain_r || s1_first_done_r || !two;
    s1_adv   = s1_vld_r && (!has_job || (job_rdy && job_last));

    // row start: last pixel of the row two up, from the window before the shift
    win_r1 = '{left: s1_wge2_r ? p1 : p2, mid: p2, right: p2};
    win_r2 = '{left: s1_cis1_r ? p2 : p1, mid: p2, right: newcol};
    // frame end: last column of the row above
    win_r3 = '{left: s1_wge2_r ? p2 : newcol, mid: newcol, right: newcol};
    win_dr = '{left:  '{top: up_rd[0], mid: lo_rd[0], bot: lo_rd[0]},
               mid:   '{top: up_rd[1], mid: lo_rd[1], bot: lo_rd[1]},
               right: '{top: up_rd[2], mid: lo_rd[2], bot: lo_rd[2]}};

    if (s1_is_drain_r) begin
      job.win  = fix_top(win_dr, s1_top23_r);
      job.meta = '{col: s1_col2_r, row: s1_row23_r, eof: s1_dlast_r, last: 1'b1};
    end else if (s1_first_done_r || (!s1_j1_r && !s1_j2_r)) begin
      job.win  = fix_top(win_r3, s1_top23_r);
      job.meta = '{col: s1_colw_r, row: s1_row23_r, eof: 1'b0, last: 1'b1};
    end else if (s1_j1_r) begin
      job.win  = fix_top(win_r1, s1_top1_r);
      job.meta = '{col: s1_colw_r, row: s1_row1_r, eof: 1'b0, last: !two};
    end else begin
      job.win  = fix_top(win_r2, s1_top23_r);
      job.meta = '{col: s1_col2_r, row: s1_row23_r, eof: 1'b0, last: !two};
    end
  end

  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r        <= 1'b0;
      s1_first_done_r <= 1'b0;
    end else begin
      if (in_ready) s1_vld_r <= s1_load;
      if (s1_adv) s1_first_done_r <= 1'b0;
      else if (job_vld && job_rdy) s1_first_done_r <= 1'b1;
    end
  end

  conv3_mac #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_mac (
    .clk              (clk),
    .rst_n            (rst_n),
    .coeff_top        (coeff_top_r),
    .coeff_mid        (coeff_mid_r),
    .coeff_bot        (coeff_bot_r),
    .job_vld          (job_vld),
    .job              (job),
    .job_rdy          (job_rdy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_col          (out_col),
    .out_row          (out_row),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_run  (out_last_of_run)
  );

`ifndef SYNTHESIS
  a_drain_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type && drain_pend_r) |=> (s1_vld_r && s1_is_drain_r))
    else $error("pending drain transfer did not reach stage 1");

  a_second_job: assert property (@(posedge clk) disable iff (!rst_n)
    s1_first_done_r |-> (s1_vld_r && !s1_is_drain_r && s1_j3_r))
    else $error("second job outside a frame end item");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_req_type) |=>
      (!drain_pend_r || (col_count_r == '0 && row_count_r == '0)))
    else $error("drains pending without position wrap");
`endif

endmodule

`default_nettype wire
